/* hw/rtl/hfe_pkg.sv */
// shared constants and types for the hfe cell to flux interval decoder
`timescale 1ns / 1ps
`default_nettype none

package hfe_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int BITRATE_W  = 16;
    localparam int RATE_W     = 27;
    localparam int DIV_W      = 5;
    localparam int IV_W       = 16;
    localparam int DEN_W      = 31;
    localparam int DEN1_W     = 26;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_V3_OPCODES  = 3'd0;
    localparam t_reg_idx REG_START_RATE  = 3'd1;
    localparam t_reg_idx REG_SAMPLE_RATE = 3'd2;
    localparam t_reg_idx REG_EMU_CLOCK   = 3'd3;
    localparam t_reg_idx REG_GAP_DIV     = 3'd4;

    localparam logic [3:0]  OP_NIBBLE  = 4'hF;
    localparam logic [7:0]  OP_BITRATE = 8'hF2;
    localparam logic [7:0]  OP_SKIP    = 8'hF3;

    localparam logic [RATE_W-1:0] KBPS_SCALE   = RATE_W'(1000);
    localparam logic [RATE_W-1:0] BR_ARG_SCALE = RATE_W'(2000);

    localparam logic [IV_W-1:0]      MAX_INTERVAL  = '1;
    localparam logic [BITRATE_W-1:0] RST_BITRATE   = BITRATE_W'(250);
    localparam logic [RATE_W-1:0]    RST_SAMPLE_HZ = RATE_W'(12500000);
    localparam logic [RATE_W-1:0]    RST_EMU_HZ    = RATE_W'(36000000);
    localparam logic [DIV_W-1:0]     RST_GAP_DIV   = DIV_W'(2);

endpackage

`default_nettype wire

/* hw/rtl/hfe_cell_to_flux_interval.sv */
// hfe track byte to flux interval decoder with shared multiplier and divider
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------
//  in       | input     | i_in_valid / o_in_stall | i_raw_byte
//  out      | output    | o_out_valid / i_out_stall | o_interval_samples, o_last
//  cfg      | input     | apb psel/penable/pready | paddr, pwdata, prdata
//
// opcode, argument and dropped bytes are taken in S_IDLE alone; a bitrate argument
// holds the input through S_DIVCHK, S_DIV (skipped when the result saturates) and
// S_DONE; a cell byte holds it through S_DEN1, S_DEN2, S_CELL per bit, the 16 step
// restoring divider and S_DONE per one cell, and S_FLUSH, using the shared multiplier
// synchronous active low reset clears the sequencer, flags and cell count
// a stalled output only holds the sequencer when a new interval must be pushed
`timescale 1ns / 1ps
`default_nettype none

module hfe_cell_to_flux_interval #(
    parameter int CELL_COUNT_BITS = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    input  wire  [7:0]                        i_raw_byte,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output logic [hfe_pkg::IV_W-1:0]          o_interval_samples,
    output logic                              o_last,
    input  wire                               i_out_stall,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [hfe_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire  [hfe_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [hfe_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import hfe_pkg::*;

    localparam int A_W   = (CELL_COUNT_BITS > DEN1_W) ? CELL_COUNT_BITS : DEN1_W;
    localparam int NUM_W = A_W + RATE_W;
    localparam int HI_W  = NUM_W - IV_W;

    typedef enum logic [2:0] {
        S_IDLE, S_DEN1, S_DEN2, S_CELL, S_DIVCHK, S_DIV, S_DONE, S_FLUSH
    } t_state;

    t_state r_state;

    logic                       r_v3;
    logic [BITRATE_W-1:0]       r_start_rate;
    logic [RATE_W-1:0]          r_sample_hz;
    logic [RATE_W-1:0]          r_emu_hz;
    logic [DIV_W-1:0]           r_gap_div;

    logic [BITRATE_W-1:0]       r_bitrate;
    logic [CELL_COUNT_BITS-1:0] r_cells;
    logic                       r_await_br;
    logic                       r_await_skip;
    logic                       r_drop;

    logic [7:0]                 r_bits;
    logic [2:0]                 r_bit;
    logic                       r_is_br;
    logic [DEN_W-1:0]           r_den;
    logic [NUM_W-1:0]           r_num;
    logic [DEN_W-1:0]           r_rem;
    logic [IV_W-1:0]            r_lo;
    logic [IV_W-1:0]            r_q;
    logic [3:0]                 r_step;
    logic [IV_W-1:0]            r_pend;
    logic                       r_pend_valid;

    logic                       r_out_valid;
    logic [IV_W-1:0]            r_out_iv;
    logic                       r_out_last;

    logic [7:0]                 f;
    logic [A_W-1:0]             mul_a;
    logic [RATE_W-1:0]          mul_b;
    logic [NUM_W-1:0]           mul_p;
    logic [CELL_COUNT_BITS-1:0] n_cells;
    logic [BITRATE_W-1:0]       br_eff;
    logic [DIV_W-1:0]           dv_eff;
    logic [DEN_W:0]             rem2;
    logic                       rem_ge;
    logic                       out_free;
    logic                       out_push;
    logic                       in_acc;
    logic                       cfg_wr;
    t_reg_idx                   cfg_idx;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            f[7-k] = i_raw_byte[k];
        end
    end

    assign n_cells  = (r_cells == '1) ? r_cells : r_cells + 1'b1;
    assign br_eff   = (r_bitrate == '0) ? BITRATE_W'(1) : r_bitrate;
    assign dv_eff   = (r_gap_div == '0) ? DIV_W'(1) : r_gap_div;
    assign rem2     = {r_rem, r_lo[IV_W-1]};
    assign rem_ge   = rem2 >= {1'b0, r_den};
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_push = out_free && r_pend_valid &&
                      ((r_state == S_DONE && !r_is_br && r_q != '0) || r_state == S_FLUSH);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[CFG_ADDR_W-1:2];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_IDLE: begin
                mul_a = A_W'(f);
                mul_b = BR_ARG_SCALE;
            end
            S_DEN1: begin
                mul_a = A_W'(br_eff);
                mul_b = KBPS_SCALE;
            end
            S_DEN2: begin
                mul_a = A_W'(r_den[DEN1_W-1:0]);
                mul_b = RATE_W'(dv_eff);
            end
            S_CELL: begin
                mul_a = A_W'(n_cells);
                mul_b = r_sample_hz;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_v3         <= 1'b0;
            r_start_rate <= RST_BITRATE;
            r_sample_hz  <= RST_SAMPLE_HZ;
            r_emu_hz     <= RST_EMU_HZ;
            r_gap_div    <= RST_GAP_DIV;
            r_bitrate    <= RST_BITRATE;
            r_cells      <= '0;
            r_await_br   <= 1'b0;
            r_await_skip <= 1'b0;
            r_drop       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_is_br      <= 1'b0;
            r_bit        <= '0;
            r_step       <= '0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_V3_OPCODES:  r_v3 <= pwdata[0];
                    REG_START_RATE: begin
                        r_start_rate <= pwdata[BITRATE_W-1:0];
                        r_bitrate    <= pwdata[BITRATE_W-1:0];
                    end
                    REG_SAMPLE_RATE: r_sample_hz <= pwdata[RATE_W-1:0];
                    REG_EMU_CLOCK:   r_emu_hz    <= pwdata[RATE_W-1:0];
                    REG_GAP_DIV:     r_gap_div   <= pwdata[DIV_W-1:0];
                    default: ;
                endcase
            end

            if (out_push) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_is_br <= r_v3 && r_await_br && (f != 8'd0);
                        if (r_v3 && r_await_br) begin
                            r_await_br <= 1'b0;
                            if (f != 8'd0) begin
                                r_den   <= DEN_W'(mul_p);
                                r_num   <= NUM_W'(r_emu_hz);
                                r_state <= S_DIVCHK;
                            end
                        end else if (r_v3 && r_await_skip) begin
                            r_await_skip <= 1'b0;
                            r_drop       <= (f != 8'd0);
                        end else if (r_v3 && r_drop) begin
                            r_drop <= 1'b0;
                        end else if (r_v3 && f[7:4] == OP_NIBBLE) begin
                            if (f == OP_BITRATE) r_await_br <= 1'b1;
                            if (f == OP_SKIP) r_await_skip <= 1'b1;
                        end else begin
                            r_bits  <= i_raw_byte;
                            r_bit   <= '0;
                            r_state <= S_DEN1;
                        end
                    end
                end
                S_DEN1: begin
                    r_den   <= DEN_W'(mul_p);
                    r_state <= S_DEN2;
                end
                S_DEN2: begin
                    r_den   <= DEN_W'(mul_p);
                    r_state <= S_CELL;
                end
                S_CELL: begin
                    if (r_bits[0]) begin
                        r_cells <= '0;
                        r_num   <= mul_p;
                        r_state <= S_DIVCHK;
                    end else begin
                        r_cells <= n_cells;
                        r_bits  <= {1'b0, r_bits[7:1]};
                        r_bit   <= r_bit + 1'b1;
                        r_state <= (r_bit == 3'd7) ? S_FLUSH : S_CELL;
                    end
                end
                S_DIVCHK: begin
                    // quotient saturates when it would reach 2^16
                    if (r_num[NUM_W-1:IV_W] >= HI_W'(r_den)) begin
                        r_q     <= MAX_INTERVAL;
                        r_state <= S_DONE;
                    end else begin
                        r_rem   <= r_num[IV_W +: DEN_W];
                        r_lo    <= r_num[IV_W-1:0];
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem_ge) begin
                        r_rem <= DEN_W'(rem2 - {1'b0, r_den});
                    end else begin
                        r_rem <= rem2[DEN_W-1:0];
                    end
                    r_q    <= {r_q[IV_W-2:0], rem_ge};
                    r_lo   <= {r_lo[IV_W-2:0], 1'b0};
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd15) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (r_is_br) begin
                        r_bitrate <= (r_q == '0) ? BITRATE_W'(1) : r_q;
                        r_state   <= S_IDLE;
                    end else if (!(r_q != '0 && r_pend_valid && !out_free)) begin
                        if (r_q != '0) begin
                            if (r_pend_valid) begin
                                r_out_iv    <= r_pend;
                                r_out_last  <= 1'b0;
                            end
                            r_pend       <= r_q;
                            r_pend_valid <= 1'b1;
                        end
                        r_bits  <= {1'b0, r_bits[7:1]};
                        r_bit   <= r_bit + 1'b1;
                        r_state <= (r_bit == 3'd7) ? S_FLUSH : S_CELL;
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_iv     <= r_pend;
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_V3_OPCODES:  prdata = CFG_DATA_W'(r_v3);
            REG_START_RATE:  prdata = CFG_DATA_W'(r_start_rate);
            REG_SAMPLE_RATE: prdata = CFG_DATA_W'(r_sample_hz);
            REG_EMU_CLOCK:   prdata = CFG_DATA_W'(r_emu_hz);
            REG_GAP_DIV:     prdata = CFG_DATA_W'(r_gap_div);
            default:         prdata = '0;
        endcase
    end

    assign pready             = 1'b1;
    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_interval_samples = r_out_iv;
    assign o_last             = r_out_last;

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_pend_valid)
        else $error("pending interval left behind at idle");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_den)
        else $error("divider remainder out of range");

    a_no_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_interval_samples != '0)
        else $error("zero interval transfer");

    a_flush_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && !r_pend_valid) |=> r_state == S_IDLE)
        else $error("flush did not return to idle");

endmodule

`default_nettype wire
